/* rtl/core/mwpo_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_pkg
// Shared types, register indexes, wave codes and the sine table builder for
// the multi-waveform phase oscillator.
// ----------------------------------------------------------------------------
package mwpo_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int PHASE_BITS_DEF      = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int MODE_W     = 3;
   localparam int VOLUME_W   = 16;
   localparam int STEP_W     = 32;
   localparam int SAMPLE_W   = 16;
   localparam int BASE_W     = SAMPLE_W + 1;
   localparam int ROM_W      = SAMPLE_W - 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 2'd2;

   // wave codes
   localparam logic [MODE_W-1:0] WAVE_SILENCE  = 3'd0;
   localparam logic [MODE_W-1:0] WAVE_SINE     = 3'd1;
   localparam logic [MODE_W-1:0] WAVE_SQUARE   = 3'd2;
   localparam logic [MODE_W-1:0] WAVE_SAW      = 3'd3;
   localparam logic [MODE_W-1:0] WAVE_TRIANGLE = 3'd4;

   localparam logic [VOLUME_W-1:0] UNITY_GAIN = 16'h8000;

   typedef struct packed {
      logic restart;
      logic block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_last;
   } rsp_type;

   // One entry of the quarter-wave table: Q30 odd polynomial for
   // sin(pi/2 * t), Horner form, truncating products, rounded half up.
   function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned bits);
      longint q30_one;
      longint t;
      longint t2;
      longint acc;
      longint y;
      q30_one = longint'(1) << 30;
      t   = longint'(k) * (longint'(1) << (30 - bits));
      t2  = (t * t) / 64'sd1073741824;
      acc = 64'sd172272;
      acc = 64'sd5026995    - (acc * t2) / 64'sd1073741824;
      acc = 64'sd85569306   - (acc * t2) / 64'sd1073741824;
      acc = 64'sd693598668  - (acc * t2) / 64'sd1073741824;
      acc = 64'sd1686629713 - (acc * t2) / 64'sd1073741824;
      y   = (acc * t) / 64'sd1073741824;
      if (y < 0) begin
         y = 0;
      end
      y = (y * 32767 + (q30_one >> 1)) / 64'sd1073741824;
      if (y > 32767) begin
         y = 32767;
      end
      return y[ROM_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/multi_waveform_phase_oscillator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator
// Phase accumulator oscillator with silence, sine, square, saw and triangle
// waves and a Q15 output gain.
// ----------------------------------------------------------------------------
// Path from req accept to rsp_valid: phase add, table read and
//   gain multiply, each into its own register.
// Throughput: one word per cycle while rsp_ready does not stall the pipe; the sine table read is registered.
// Reset: phase 0, wave_mode sine, volume unity, phase_step 0, pipe empty.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator #(
   parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  mwpo_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output mwpo_pkg::rsp_type                   rsp_data,
   input  wire                                 csr_we,
   input  wire  [mwpo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [mwpo_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RomSpan = 1 << SINE_TABLE_BITS;
   localparam int StepUse = (PHASE_BITS < mwpo_pkg::STEP_W) ? PHASE_BITS : mwpo_pkg::STEP_W;

   // configuration
   logic [mwpo_pkg::MODE_W-1:0]   wave_mode_ff;
   logic [mwpo_pkg::VOLUME_W-1:0] volume_ff;
   logic [mwpo_pkg::STEP_W-1:0]   phase_step_ff;

   // stage 1: phase
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  s1_valid_ff, s1_last_ff;

   // stage 2: base wave
   logic                            s2_valid_ff, s2_last_ff;
   logic                            sel_sine_ff, neg_ff;
   logic [mwpo_pkg::ROM_W-1:0]      rom_q_ff;
   logic signed [mwpo_pkg::BASE_W-1:0] alt_base_ff, alt_base_in;

   // stage 3: output
   logic              rsp_valid_ff;
   mwpo_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                    adv, accept, mode_active, silent;
   logic [PHASE_BITS-1:0]   step_ext;
   logic [1:0]              quad;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [SINE_TABLE_BITS:0]   rom_addr;
   logic [15:0]             x;
   logic signed [18:0]      tri_v;
   logic [mwpo_pkg::ROM_W-1:0] sine_rom [RomSpan+1];

   logic signed [mwpo_pkg::BASE_W-1:0]  base;
   logic [mwpo_pkg::VOLUME_W-1:0]       gain;
   logic signed [2*mwpo_pkg::BASE_W-1:0] prod, biased;

   for (genvar k = 0; k <= RomSpan; k++) begin : g_rom
      assign sine_rom[k] = mwpo_pkg::sine_entry(k, SINE_TABLE_BITS);
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mode_active = (wave_mode_ff == mwpo_pkg::WAVE_SINE)   ||
                        (wave_mode_ff == mwpo_pkg::WAVE_SQUARE) ||
                        (wave_mode_ff == mwpo_pkg::WAVE_SAW)    ||
                        (wave_mode_ff == mwpo_pkg::WAVE_TRIANGLE);
   assign silent   = !mode_active;
   assign step_ext = PHASE_BITS'(phase_step_ff[StepUse-1:0]);

   // restart clears before the step; inactive modes hold phase
   always_comb begin
      phase_in = req_data.restart ? '0 : phase_ff;
      if (mode_active) begin
         phase_in = phase_in + step_ext;
      end
   end

   // base waves from the current phase
   assign quad     = phase_ff[PHASE_BITS-1 -: 2];
   assign idx      = phase_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign rom_addr = quad[0] ? ((SINE_TABLE_BITS+1)'(RomSpan) - {1'b0, idx}) : {1'b0, idx};
   assign x        = phase_ff[PHASE_BITS-1 -: 16];

   always_comb begin
      if (x < 16'd16384) begin
         tri_v = $signed({2'b00, x, 1'b0});
      end else if (x < 16'd49152) begin
         tri_v = 19'sd65536 - $signed({2'b00, x, 1'b0});
      end else begin
         tri_v = $signed({2'b00, x, 1'b0}) - 19'sd131072;
      end
      if (tri_v == 19'sd32768) begin
         tri_v = 19'sd32767;
      end
   end

   always_comb begin
      unique case (wave_mode_ff)
         mwpo_pkg::WAVE_SQUARE:   alt_base_in = x[15] ? -17'sd32767 : 17'sd32767;
         mwpo_pkg::WAVE_SAW:      alt_base_in = {x[15], x};
         mwpo_pkg::WAVE_TRIANGLE: alt_base_in = tri_v[mwpo_pkg::BASE_W-1:0];
         default:                 alt_base_in = '0;
      endcase
   end

   // gain stage, truncation toward zero
   always_comb begin
      base = neg_ff ? -$signed({2'b00, rom_q_ff}) : $signed({2'b00, rom_q_ff});
      if (!sel_sine_ff) begin
         base = alt_base_ff;
      end
      gain   = (volume_ff > mwpo_pkg::UNITY_GAIN) ? mwpo_pkg::UNITY_GAIN : volume_ff;
      prod   = base * $signed({1'b0, gain});
      biased = prod + (prod[2*mwpo_pkg::BASE_W-1] ? (2*mwpo_pkg::BASE_W)'(32767) : '0);
      rsp_data_in.sample     = biased[30:15];
      rsp_data_in.block_last = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff  <= mwpo_pkg::WAVE_SINE;
         volume_ff     <= mwpo_pkg::UNITY_GAIN;
         phase_step_ff <= '0;
         phase_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
         end
         if (adv) begin
            s1_valid_ff  <= req_valid;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
         if (csr_we) begin
            unique case (csr_index)
               mwpo_pkg::CSR_WAVE_MODE: begin
                  wave_mode_ff <= csr_wdata[mwpo_pkg::MODE_W-1:0];
                  phase_ff     <= '0;
               end
               mwpo_pkg::CSR_VOLUME:     volume_ff     <= csr_wdata[mwpo_pkg::VOLUME_W-1:0];
               mwpo_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wdata[mwpo_pkg::STEP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff  <= req_data.block_end;
         s2_last_ff  <= s1_last_ff;
         rom_q_ff    <= sine_rom[rom_addr];
         neg_ff      <= quad[1];
         sel_sine_ff <= (wave_mode_ff == mwpo_pkg::WAVE_SINE);
         alt_base_ff <= alt_base_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a stalled pipe must not move the accumulator
   a_stall_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && !csr_we |=> $stable(phase_ff))
      else $error("phase moved during stall");

   a_silent_hold: assert property (@(posedge clock) disable iff (reset)
      accept && silent && !req_data.restart && !csr_we |=> $stable(phase_ff))
      else $error("phase advanced in silent mode");

   a_restart_step: assert property (@(posedge clock) disable iff (reset)
      accept && mode_active && req_data.restart && !csr_we |=> phase_ff == $past(step_ext))
      else $error("restart did not reload phase with one step");

   a_silent_base: assert property (@(posedge clock) disable iff (reset)
      adv && silent |=> !sel_sine_ff && alt_base_ff == '0)
      else $error("silent mode produced a nonzero base");

endmodule
`default_nettype wire
